// ----- rtl/idq_pkg.sv -----
`timescale 1ns / 1ps

package idq_pkg;

  // Ring geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = ADDR_W + 1;

  // Request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_AT    = 3'd4,
    REQ_WRITE_AT   = 3'd5
  } req_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  position;
    logic [31:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_beat_t;

  // Physical slot of the entry at offset off from base, modulo DEPTH
  function automatic logic [ADDR_W-1:0] slot_of(logic [ADDR_W-1:0] base,
                                                logic [ADDR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/idq_ram.sv -----
`timescale 1ns / 1ps

module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/indexed_deque_store.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Beat type
// in_       in   in_valid / in_stall   idq_pkg::in_beat_t  (req_type, position, data_in)
// out_      out  out_valid / out_stall idq_pkg::out_beat_t (read_data, status, entry_count)
//
// One request per cycle while in_stall is low; each result passes the read stage, then
// the output register. Front pointer and count live in registers; entries live in a
// single-port RAM written in the accept cycle and read through a registered port.
// Reset clears pointer, count and valid flags; the entry RAM is not cleared.
// A stalled output holds one result and one more in the read stage, then in_stall rises.

module indexed_deque_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  idq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output idq_pkg::out_beat_t out_data
);

  logic [idq_pkg::ADDR_W-1:0] front_r, front_nxt;
  logic [idq_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic                   s1_valid_r;
  idq_pkg::status_t       s1_status_r;
  logic [idq_pkg::CNT_W-1:0] s1_count_r;
  logic                   s1_rd_r;

  logic               out_valid_r;
  idq_pkg::out_beat_t out_data_r;

  logic                       accept, s1_adv;
  logic                       ram_we, ram_re, rd_hit;
  logic [idq_pkg::ADDR_W-1:0] ram_addr;
  logic [idq_pkg::DATA_WIDTH-1:0] ram_rdata;
  idq_pkg::status_t           status;
  logic                       full, empty, out_range;
  logic [idq_pkg::ADDR_W-1:0] pos_off;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign full      = (count_r == idq_pkg::CNT_W'(idq_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign out_range = ({{(idq_pkg::CNT_W > 6 ? idq_pkg::CNT_W - 6 : 0){1'b0}},
                       in_data.position} >= count_r);
  assign pos_off   = idq_pkg::ADDR_W'(in_data.position);

  // Decode request: pick slot, status and next pointer and count
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    status    = idq_pkg::ST_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_hit    = 1'b0;
    ram_addr  = front_r;
    case (idq_pkg::req_t'(in_data.req_type))
      idq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ram_addr  = idq_pkg::slot_of(front_r, idq_pkg::ADDR_W'(idq_pkg::DEPTH - 1));
          front_nxt = ram_addr;
          count_nxt = count_r + idq_pkg::CNT_W'(1);
          ram_we    = 1'b1;
        end
      end
      idq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ram_addr  = idq_pkg::slot_of(front_r, count_r[idq_pkg::ADDR_W-1:0]);
          count_nxt = count_r + idq_pkg::CNT_W'(1);
          ram_we    = 1'b1;
        end
      end
      idq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          front_nxt = idq_pkg::slot_of(front_r, idq_pkg::ADDR_W'(1));
          count_nxt = count_r - idq_pkg::CNT_W'(1);
        end
      end
      idq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status = idq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - idq_pkg::CNT_W'(1);
        end
      end
      idq_pkg::REQ_READ_AT: begin
        if (out_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          ram_addr = idq_pkg::slot_of(front_r, pos_off);
          ram_re   = 1'b1;
          rd_hit   = 1'b1;
        end
      end
      idq_pkg::REQ_WRITE_AT: begin
        if (out_range) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          ram_addr = idq_pkg::slot_of(front_r, pos_off);
          ram_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  idq_ram #(
    .WIDTH (idq_pkg::DATA_WIDTH),
    .DEPTH (idq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && ram_we),
    .re    (accept && ram_re),
    .addr  (ram_addr),
    .wdata (idq_pkg::DATA_WIDTH'(in_data.data_in)),
    .rdata (ram_rdata)
  );

  // Advance pointer, count, read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_valid_r && s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        front_r    <= front_nxt;
        count_r    <= count_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Hold payload of the read stage and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
      s1_rd_r     <= rd_hit;
    end
    if (s1_valid_r && s1_adv) begin
      out_data_r.read_data   <= s1_rd_r ? 32'(ram_rdata) : 32'd0;
      out_data_r.status      <= s1_status_r;
      out_data_r.entry_count <= 7'(s1_count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/idq_checker.sv -----
`timescale 1ns / 1ps

module idq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input idq_pkg::out_beat_t out_data
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Count never exceeds the ring depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 7'(idq_pkg::DEPTH))
    else $error("entry count above depth");

  // Failed requests return no data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != idq_pkg::ST_OK |-> out_data.read_data == 32'd0)
    else $error("nonzero data on failed request");

  // Full flag only at depth, empty flag only at zero
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == idq_pkg::ST_FULL
      |-> out_data.entry_count == 7'(idq_pkg::DEPTH))
    else $error("full status with count below depth");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == idq_pkg::ST_EMPTY |-> out_data.entry_count == 7'd0)
    else $error("empty status with nonzero count");

endmodule

bind indexed_deque_store idq_checker u_idq_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import idq_pkg::*;

  // Request codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 60;
  localparam int HOLD_AFTER  = 150;
  localparam int REPORT_MAX  = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  bit burst_mode;
  int idle_cycles;

  indexed_deque_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow deque plus the queue of responses it predicts
  class deque_scoreboard;
    logic [31:0]       slot_word [DEPTH];
    logic [ADDR_W-1:0] front;
    logic [CNT_W-1:0]  held;
    out_beat_t         expected_responses [$];
    int                errors;

    function new();
      front  = '0;
      held   = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function out_beat_t predict_response(in_beat_t b);
      out_beat_t         r;
      logic [ADDR_W-1:0] slot;
      r.read_data = '0;
      r.status    = ST_OK;
      slot        = front + b.position;
      case (b.req_type)
        REQ_PUSH_FRONT: begin
          if (held == CNT_W'(DEPTH)) begin
            r.status = ST_FULL;
          end else begin
            front            = front - ADDR_W'(1);
            slot_word[front] = b.data_in;
            held             = held + CNT_W'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (held == CNT_W'(DEPTH)) begin
            r.status = ST_FULL;
          end else begin
            slot_word[front + held[ADDR_W-1:0]] = b.data_in;
            held = held + CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (held == '0) begin
            r.status = ST_EMPTY;
          end else begin
            front = front + ADDR_W'(1);
            held  = held - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (held == '0) begin
            r.status = ST_EMPTY;
          end else begin
            held = held - CNT_W'(1);
          end
        end
        REQ_READ_AT: begin
          if (CNT_W'(b.position) >= held) begin
            r.status = ST_RANGE;
          end else begin
            r.read_data = slot_word[slot];
          end
        end
        REQ_WRITE_AT: begin
          if (CNT_W'(b.position) >= held) begin
            r.status = ST_RANGE;
          end else begin
            slot_word[slot] = b.data_in;
          end
        end
        default: begin
        end
      endcase
      r.entry_count = held;
      return r;
    endfunction

    function void note_request(in_beat_t b);
      expected_responses.push_back(predict_response(b));
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      if (errors <= REPORT_MAX)
        $error("%s: expected %0h, actual %0h", field, exp_v, act_v);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_r;
      if (expected_responses.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $error("result beat with no request outstanding: %0h", got);
        return;
      end
      exp_r = expected_responses.pop_front();
      if (got.read_data !== exp_r.read_data)
        report("read_data", exp_r.read_data, got.read_data);
      if (got.status !== exp_r.status)
        report("status", 32'(exp_r.status), 32'(got.status));
      if (got.entry_count !== exp_r.entry_count)
        report("entry_count", 32'(exp_r.entry_count), 32'(got.entry_count));
    endfunction
  endclass

  deque_scoreboard sb;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Record accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
    end
  end

  // Abort when the handshakes stop moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stall per beat outside burst mode, one long hold-off
  initial begin
    int  hold_left;
    int  beats_taken;
    bit  held_long;
    hold_left   = 0;
    beats_taken = 0;
    held_long   = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        beats_taken++;
        hold_left = burst_mode ? 0 : $urandom_range(0, 3);
        if (!held_long && beats_taken >= HOLD_AFTER) begin
          hold_left = LONG_HOLD;
          held_long = 1'b1;
        end
      end
    end
  end

  // Idle the request bus for a drawn gap; return at the negedge that drives the next beat
  task automatic wait_gap();
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Offer one beat and hold it until taken
  task automatic put_beat(in_beat_t b);
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_req(logic [2:0] rt, logic [5:0] pos, logic [31:0] d);
    in_beat_t b;
    b.req_type = rt;
    b.position = pos;
    b.data_in  = d;
    wait_gap();
    put_beat(b);
  endtask

  // Draw a request, weighted toward pushes or pops; positions mostly in range
  function automatic in_beat_t make_request(int push_w, int pop_w);
    in_beat_t b;
    int       pick;
    pick       = $urandom_range(0, 99);
    b.position = 6'($urandom_range(0, 63));
    b.data_in  = $urandom();
    if (pick < push_w) begin
      b.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else if (pick < push_w + pop_w) begin
      b.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    end else if (pick < 97) begin
      b.req_type = $urandom_range(0, 1) ? REQ_WRITE_AT : REQ_READ_AT;
      if (sb.held != '0 && $urandom_range(0, 99) < 80)
        b.position = 6'($urandom_range(0, int'(sb.held) - 1));
    end else begin
      b.req_type = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    end
    return b;
  endfunction

  task automatic send_random(int count, int push_w, int pop_w);
    repeat (count) begin
      wait_gap();
      put_beat(make_request(push_w, pop_w));
    end
  endtask

  // Drop valid and hold off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Main sequence
  initial begin
    sb         = new();
    burst_mode = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty-queue errors and no-op codes
    send_req(REQ_POP_FRONT,  6'd0,  32'h0);
    send_req(REQ_POP_BACK,   6'd0,  32'hFFFF_FFFF);
    send_req(REQ_READ_AT,    6'd0,  32'h0);
    send_req(REQ_WRITE_AT,   6'd63, 32'hFFFF_FFFF);
    send_req(REQ_SPARE_LO,   6'd0,  32'h0);
    send_req(REQ_SPARE_HI,   6'd63, 32'hFFFF_FFFF);
    // Pushes at both ends with extreme words
    send_req(REQ_PUSH_BACK,  6'd63, 32'hFFFF_FFFF);
    send_req(REQ_PUSH_FRONT, 6'd0,  32'h0);
    send_req(REQ_PUSH_BACK,  6'd0,  32'hA5A5_A5A5);
    send_req(REQ_PUSH_FRONT, 6'd63, 32'h5A5A_5A5A);
    // Positional reads, including past the count
    send_req(REQ_READ_AT,    6'd0,  32'h0);
    send_req(REQ_READ_AT,    6'd1,  32'h0);
    send_req(REQ_READ_AT,    6'd2,  32'h0);
    send_req(REQ_READ_AT,    6'd3,  32'h0);
    send_req(REQ_READ_AT,    6'd4,  32'h0);
    send_req(REQ_READ_AT,    6'd63, 32'h0);
    // Overwrites, then pops from both ends
    send_req(REQ_WRITE_AT,   6'd3,  32'h1234_5678);
    send_req(REQ_WRITE_AT,   6'd0,  32'hFFFF_FFFF);
    send_req(REQ_READ_AT,    6'd3,  32'h0);
    send_req(REQ_POP_FRONT,  6'd0,  32'h0);
    send_req(REQ_POP_BACK,   6'd0,  32'h0);
    send_req(REQ_READ_AT,    6'd0,  32'h0);
    send_req(REQ_READ_AT,    6'd1,  32'h0);
    send_req(REQ_WRITE_AT,   6'd63, 32'h0);

    // Fill past full, mix, drain past empty, burst, refill
    send_random(120, 70, 10);
    send_random(100, 30, 30);
    send_random(120, 10, 70);
    drain_results();
    burst_mode = 1'b1;
    send_random(80, 40, 40);
    burst_mode = 1'b0;
    send_random(80, 60, 15);

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
